/* rtl/lrb_pkg.sv */
// ----------------------------------------------------------------------------
// lrb_pkg
// Types, codes and helpers for the link reconnect backoff state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package lrb_pkg;

  // Connection manager states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_NOCRED     = 6'b000010,
    ST_CONNECTING = 6'b000100,
    ST_CONNECTED  = 6'b001000,
    ST_WAIT       = 6'b010000,
    ST_PROV       = 6'b100000
  } lrb_state_e;

  // Event codes carried in tuser
  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_INIT       = 3'd1,
    MODE_CONNECT    = 3'd2,
    MODE_PROV_START = 3'd3,
    MODE_PROV_STOP  = 3'd4,
    MODE_SHUTDOWN   = 3'd5
  } lrb_mode_e;

  // Reported link state codes
  localparam logic [2:0] LS_IDLE       = 3'd0;
  localparam logic [2:0] LS_NOCRED     = 3'd1;
  localparam logic [2:0] LS_CONNECTING = 3'd2;
  localparam logic [2:0] LS_CONNECTED  = 3'd3;
  localparam logic [2:0] LS_WAIT       = 3'd4;
  localparam logic [2:0] LS_PROV       = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_CONNECT_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_BACKOFF_MIN     = 2'd1;
  localparam logic [1:0] REG_BACKOFF_MAX     = 2'd2;
  localparam logic [1:0] REG_HAS_CRED        = 2'd3;

  localparam logic [31:0] TIMEOUT_RST     = 32'd15000;
  localparam logic [30:0] BACKOFF_MIN_RST = 31'd1000;
  localparam logic [30:0] BACKOFF_MAX_RST = 31'd60000;

  typedef struct packed {
    logic [31:0] attempt_tmo_ms;
    logic [30:0] backoff_min_ms;
    logic [30:0] backoff_max_ms;
    logic        has_credentials;
  } lrb_cfg_t;

  typedef struct packed {
    lrb_state_e  fsm_state;
    logic [31:0] attempt_start_ms;
    logic [30:0] backoff_cur_ms;
    logic [31:0] deadline_ms;
    logic [31:0] attempts;
    logic [31:0] disconnects;
    logic [31:0] consecutive_fails;
  } lrb_ctx_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic        link_up;
    logic        ssid_given;
  } lrb_item_t;

  typedef struct packed {
    logic [30:0] backoff_now_ms;
    logic [31:0] failure_run;
    logic [31:0] disconnect_total;
    logic [31:0] attempt_count;
    logic        accepted;
    logic        drop_link;
    logic        start_attempt;
    logic        connected;
    logic [2:0]  link_state;
  } lrb_res_t;

  function automatic logic [2:0] state_code(lrb_state_e st);
    logic [2:0] code;
    case (st)
      ST_IDLE:       code = LS_IDLE;
      ST_NOCRED:     code = LS_NOCRED;
      ST_CONNECTING: code = LS_CONNECTING;
      ST_CONNECTED:  code = LS_CONNECTED;
      ST_WAIT:       code = LS_WAIT;
      ST_PROV:       code = LS_PROV;
      default:       code = LS_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/lrb_step.sv */
// ----------------------------------------------------------------------------
// lrb_step
// Next-state and result logic for one event of the connection manager.
// ----------------------------------------------------------------------------
`default_nettype none

module lrb_step
  import lrb_pkg::*;
(
  input  lrb_ctx_t  ctx_i,
  input  lrb_cfg_t  cfg_i,
  input  lrb_item_t item_i,
  output lrb_ctx_t  ctx_o,
  output lrb_res_t  res_o
);

  logic [31:0] raw_backoff;
  logic [30:0] bumped;
  logic [31:0] bump_deadline;
  logic [31:0] elapsed;
  logic [31:0] since_deadline;
  logic        timed_out;
  logic        deadline_passed;
  logic        start;
  logic        drop;
  logic        acc;
  lrb_ctx_t    nxt;

  // Zero backoff starts at the minimum, otherwise double; clamp at the maximum
  assign raw_backoff     = (ctx_i.backoff_cur_ms == '0) ? {1'b0, cfg_i.backoff_min_ms}
                                                        : {ctx_i.backoff_cur_ms, 1'b0};
  assign bumped          = (raw_backoff > {1'b0, cfg_i.backoff_max_ms}) ?
                           cfg_i.backoff_max_ms : raw_backoff[30:0];
  assign bump_deadline   = item_i.now_ms + {1'b0, bumped};
  assign elapsed         = item_i.now_ms - ctx_i.attempt_start_ms;
  assign timed_out       = (elapsed >= cfg_i.attempt_tmo_ms);
  // Wrap-safe: passed when the difference lies in the lower half range
  assign since_deadline  = item_i.now_ms - ctx_i.deadline_ms;
  assign deadline_passed = ~since_deadline[31];

  always_comb begin
    nxt   = ctx_i;
    start = 1'b0;
    drop  = 1'b0;
    acc   = 1'b0;
    case (item_i.mode)
      MODE_TICK: begin
        case (ctx_i.fsm_state)
          ST_CONNECTING: begin
            if (item_i.link_up) begin
              nxt.fsm_state         = ST_CONNECTED;
              nxt.consecutive_fails = '0;
              nxt.backoff_cur_ms    = cfg_i.backoff_min_ms;
            end else if (timed_out) begin
              nxt.consecutive_fails = ctx_i.consecutive_fails + 32'd1;
              nxt.backoff_cur_ms    = bumped;
              nxt.deadline_ms       = bump_deadline;
              nxt.fsm_state         = ST_WAIT;
              drop                  = 1'b1;
            end
          end
          ST_CONNECTED: begin
            if (!item_i.link_up) begin
              nxt.disconnects    = ctx_i.disconnects + 32'd1;
              nxt.backoff_cur_ms = bumped;
              nxt.deadline_ms    = bump_deadline;
              nxt.fsm_state      = ST_WAIT;
            end
          end
          ST_WAIT: begin
            if (deadline_passed) begin
              if (!cfg_i.has_credentials) begin
                nxt.fsm_state = ST_NOCRED;
              end else begin
                nxt.attempts         = ctx_i.attempts + 32'd1;
                nxt.attempt_start_ms = item_i.now_ms;
                nxt.fsm_state        = ST_CONNECTING;
                start                = 1'b1;
              end
            end
          end
          default: begin
            // hold in idle, no credentials and provisioning
          end
        endcase
      end
      MODE_INIT: begin
        nxt.backoff_cur_ms    = cfg_i.backoff_min_ms;
        nxt.consecutive_fails = '0;
        if (!cfg_i.has_credentials) begin
          nxt.fsm_state = ST_NOCRED;
        end else begin
          nxt.attempts         = ctx_i.attempts + 32'd1;
          nxt.attempt_start_ms = item_i.now_ms;
          nxt.fsm_state        = ST_CONNECTING;
          start                = 1'b1;
        end
      end
      MODE_CONNECT: begin
        if (item_i.ssid_given) begin
          nxt.backoff_cur_ms    = cfg_i.backoff_min_ms;
          nxt.consecutive_fails = '0;
          nxt.attempts          = ctx_i.attempts + 32'd1;
          nxt.attempt_start_ms  = item_i.now_ms;
          nxt.fsm_state         = ST_CONNECTING;
          start                 = 1'b1;
          acc                   = 1'b1;
        end
      end
      MODE_PROV_START: begin
        nxt.fsm_state = ST_PROV;
      end
      MODE_PROV_STOP: begin
        if (ctx_i.fsm_state == ST_PROV) begin
          nxt.fsm_state = ST_IDLE;
        end
      end
      MODE_SHUTDOWN: begin
        nxt.fsm_state = ST_IDLE;
      end
      default: begin
        // unused event codes leave everything as is
      end
    endcase
  end

  assign ctx_o = nxt;

  assign res_o.link_state       = state_code(nxt.fsm_state);
  assign res_o.connected        = (nxt.fsm_state == ST_CONNECTED) && item_i.link_up;
  assign res_o.start_attempt    = start;
  assign res_o.drop_link        = drop;
  assign res_o.accepted         = acc;
  assign res_o.attempt_count    = nxt.attempts;
  assign res_o.disconnect_total = nxt.disconnects;
  assign res_o.failure_run      = nxt.consecutive_fails;
  assign res_o.backoff_now_ms   = nxt.backoff_cur_ms;

endmodule

`default_nettype wire

/* rtl/link_reconnect_backoff_fsm_unit.sv */
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm_unit
// Link connection manager with exponential reconnect backoff.
// ----------------------------------------------------------------------------
// Each input item is one event (tick, init, connect request, start or stop
// provisioning, shutdown) with the current millisecond time and link status;
// each produces exactly one result item with the new state, command strobes
// and counters. An item is registered on entry, evaluated combinationally
// against the state registers and lands in the result register, so one
// item is taken every cycle while results drain, and each result is offered
// from there; the state update of one event is complete before the next is
// evaluated. While a result waits to be taken, the input register takes one
// more item and then holds the input off until the result leaves.
// Configuration writes are always accepted and belong to idle periods.
`default_nettype none

module link_reconnect_backoff_fsm_unit
  import lrb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration write channel
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  // event stream
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // tdata: now_ms[31:0], link_up[32], ssid_given[33], zero fill [39:34]
  input  wire logic [39:0]  s_axis_tdata,
  // tuser: mode[2:0]
  input  wire logic [2:0]   s_axis_tuser,
  // result stream
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: link_state[2:0], connected[3], start_attempt[4], drop_link[5],
  //        accepted[6], attempt_count[38:7], disconnect_total[70:39],
  //        failure_run[102:71], backoff_now_ms[133:103], zero fill [135:134]
  output      logic [135:0] m_axis_tdata
);

  lrb_cfg_t  cfg_q;
  lrb_ctx_t  ctx_q, ctx_d;
  lrb_item_t item_q;
  logic      item_valid_q;
  lrb_res_t  res_q, res_d;
  logic      res_valid_q;
  logic      advance;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attempt_tmo_ms  <= TIMEOUT_RST;
      cfg_q.backoff_min_ms  <= BACKOFF_MIN_RST;
      cfg_q.backoff_max_ms  <= BACKOFF_MAX_RST;
      cfg_q.has_credentials <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CONNECT_TIMEOUT: cfg_q.attempt_tmo_ms  <= cfg_data_i;
        REG_BACKOFF_MIN:     cfg_q.backoff_min_ms  <= cfg_data_i[30:0];
        REG_BACKOFF_MAX:     cfg_q.backoff_max_ms  <= cfg_data_i[30:0];
        REG_HAS_CRED:        cfg_q.has_credentials <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // Evaluate the held item when the result slot is free or draining
  assign advance       = item_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.mode       <= s_axis_tuser;
      item_q.now_ms     <= s_axis_tdata[31:0];
      item_q.link_up    <= s_axis_tdata[32];
      item_q.ssid_given <= s_axis_tdata[33];
    end
  end

  lrb_step u_step (
    .ctx_i  (ctx_q),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .ctx_o  (ctx_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.fsm_state         <= ST_IDLE;
      ctx_q.attempt_start_ms  <= '0;
      ctx_q.backoff_cur_ms    <= '0;
      ctx_q.deadline_ms       <= '0;
      ctx_q.attempts          <= '0;
      ctx_q.disconnects       <= '0;
      ctx_q.consecutive_fails <= '0;
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

  // ---------------------------------------------------------------- checks
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(ctx_q.fsm_state))
    else $error("state register not one-hot");

  a_start_connecting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.start_attempt |-> res_q.link_state == LS_CONNECTING)
    else $error("attempt started without entering connecting");

  a_drop_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.drop_link |-> res_q.link_state == LS_WAIT && !res_q.start_attempt)
    else $error("drop issued outside reconnect wait");

  a_accept_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.accepted |-> res_q.start_attempt)
    else $error("accepted request did not start an attempt");

  a_attempt_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ctx_q.attempts == $past(ctx_q.attempts) + {31'd0, $past(res_d.start_attempt)})
    else $error("attempt counter out of step with start strobe");

endmodule

`default_nettype wire

/* tb/sv/link_reconnect_backoff_fsm_unit_tb.sv */
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm_unit_tb
// Self-checking bench for the link reconnect backoff state machine. A short
// table of events walks the states, the timeout and deadline edges and the
// unused event codes. Random event streams follow under several register
// settings, timed to hit attempt timeouts and reconnect deadlines. Every
// result item is checked field by field against an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_reconnect_backoff_fsm_unit_tb;
  import lrb_pkg::*;

  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_PRINTS  = 50;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] now;
    logic        up;
    logic        named;
    bit          typed;   // link_state and strobes below are fixed by hand
    logic [2:0]  st;
    logic        conn;
    logic        start;
    logic        drop;
    logic        acc;
  } ev_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;

  // model state and registers
  logic [2:0]  lnk_state;
  logic [31:0] att_start;
  logic [30:0] backoff;
  logic [31:0] deadline;
  logic [31:0] n_attempts;
  logic [31:0] n_drops;
  logic [31:0] n_fails;
  logic [31:0] cfg_timeout;
  logic [30:0] cfg_bmin;
  logic [30:0] cfg_bmax;
  logic        cfg_cred;

  lrb_res_t    link_report_q[$];
  ev_row_t     event_table[$];
  int          mismatch_cnt = 0;
  int          quiet_cycles = 0;
  int          result_idx   = 0;
  bit          src_pace     = 1'b0;
  bit          sink_pace    = 1'b0;
  bit          hold_req     = 1'b0;
  logic [31:0] now_cur;

  link_reconnect_backoff_fsm_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  function automatic ev_row_t mk_row(logic [2:0] md, logic [31:0] t, logic up, logic nm,
                                     bit typed, logic [2:0] st, logic conn, logic start,
                                     logic drop, logic acc);
    ev_row_t r;
    r.mode = md; r.now = t; r.up = up; r.named = nm; r.typed = typed;
    r.st = st; r.conn = conn; r.start = start; r.drop = drop; r.acc = acc;
    return r;
  endfunction

  function automatic void grow_backoff();
    logic [31:0] b;
    b = (backoff == '0) ? {1'b0, cfg_bmin} : {backoff, 1'b0};
    if (b > {1'b0, cfg_bmax}) b = {1'b0, cfg_bmax};
    backoff = b[30:0];
  endfunction

  function automatic void launch_try(logic [31:0] t);
    n_attempts = n_attempts + 32'd1;
    att_start  = t;
    lnk_state  = LS_CONNECTING;
  endfunction

  // Advance the model by one event and return the report it produces.
  function automatic lrb_res_t predict_link_event(logic [2:0] md, logic [31:0] t,
                                                  logic up, logic nm);
    lrb_res_t r;
    logic go, drop, acc;
    go = 1'b0; drop = 1'b0; acc = 1'b0;
    case (md)
      MODE_TICK: begin
        if (lnk_state == LS_CONNECTING) begin
          if (up) begin
            lnk_state = LS_CONNECTED;
            n_fails   = '0;
            backoff   = cfg_bmin;
          end else if (t - att_start >= cfg_timeout) begin
            n_fails = n_fails + 32'd1;
            grow_backoff();
            deadline  = t + {1'b0, backoff};
            lnk_state = LS_WAIT;
            drop      = 1'b1;
          end
        end else if (lnk_state == LS_CONNECTED) begin
          if (!up) begin
            n_drops = n_drops + 32'd1;
            lnk_state = LS_WAIT;
            grow_backoff();
            deadline = t + {1'b0, backoff};
          end
        end else if (lnk_state == LS_WAIT) begin
          // wrap-safe: deadline passed when the distance is in the lower half
          if (t - deadline <= 32'h7FFF_FFFF) begin
            if (!cfg_cred) begin
              lnk_state = LS_NOCRED;
            end else begin
              launch_try(t);
              go = 1'b1;
            end
          end
        end
      end
      MODE_INIT: begin
        backoff = cfg_bmin;
        n_fails = '0;
        if (!cfg_cred) begin
          lnk_state = LS_NOCRED;
        end else begin
          launch_try(t);
          go = 1'b1;
        end
      end
      MODE_CONNECT: begin
        if (nm) begin
          backoff = cfg_bmin;
          n_fails = '0;
          launch_try(t);
          go  = 1'b1;
          acc = 1'b1;
        end
      end
      MODE_PROV_START: lnk_state = LS_PROV;
      MODE_PROV_STOP: begin
        if (lnk_state == LS_PROV) lnk_state = LS_IDLE;
      end
      MODE_SHUTDOWN: lnk_state = LS_IDLE;
      default: ;
    endcase
    r.link_state       = lnk_state;
    r.connected        = (lnk_state == LS_CONNECTED) && up;
    r.start_attempt    = go;
    r.drop_link        = drop;
    r.accepted         = acc;
    r.attempt_count    = n_attempts;
    r.disconnect_total = n_drops;
    r.failure_run      = n_fails;
    r.backoff_now_ms   = backoff;
    return r;
  endfunction

  task automatic report_err(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) $display("tb: mismatch at result %0d: %s", result_idx, msg);
  endtask

  task automatic check_fld(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_err($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CONNECT_TIMEOUT: cfg_timeout = val;
      REG_BACKOFF_MIN:     cfg_bmin    = val[30:0];
      REG_BACKOFF_MAX:     cfg_bmax    = val[30:0];
      REG_HAS_CRED:        cfg_cred    = val[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_event(ev_row_t row);
    lrb_res_t want;
    if (src_pace && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.mode;
    s_axis_tdata  <= {6'b0, row.named, row.up, row.now};
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_link_event(row.mode, row.now, row.up, row.named);
    if (row.typed) begin
      want.link_state    = row.st;
      want.connected     = row.conn;
      want.start_attempt = row.start;
      want.drop_link     = row.drop;
      want.accepted      = row.acc;
    end
    link_report_q.push_back(want);
  endtask

  // Drop valid at the current edge and hold until every report is back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (link_report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: ticks aimed at the timeout and deadline edges.
  task automatic send_random();
    ev_row_t row;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70)      row.mode = MODE_TICK;
    else if (r < 76) row.mode = MODE_INIT;
    else if (r < 86) row.mode = MODE_CONNECT;
    else if (r < 90) row.mode = MODE_PROV_START;
    else if (r < 93) row.mode = MODE_PROV_STOP;
    else if (r < 96) row.mode = MODE_SHUTDOWN;
    else             row.mode = 3'($urandom_range(6, 7));
    row.named = ($urandom_range(0, 4) != 0);
    r = $urandom_range(0, 9);
    if (r < 3 && lnk_state == LS_CONNECTING) begin
      row.now = att_start + cfg_timeout + $urandom_range(0, 2) - 32'd1;
    end else if (r < 3 && lnk_state == LS_WAIT) begin
      case ($urandom_range(0, 3))
        0:       row.now = deadline - 32'd1;
        1:       row.now = deadline;
        2:       row.now = deadline + 32'h7FFF_FFFF;
        default: row.now = deadline + 32'h8000_0000;
      endcase
    end else if (r < 8) begin
      row.now = now_cur + $urandom_range(0, 50);
    end else if (r == 8) begin
      row.now = now_cur + $urandom_range(0, 200000);
    end else begin
      row.now = $urandom();
    end
    now_cur = row.now;
    case (lnk_state)
      LS_CONNECTING: row.up = ($urandom_range(0, 3) == 0);
      LS_CONNECTED:  row.up = ($urandom_range(0, 4) != 0);
      default:       row.up = 1'($urandom_range(0, 1));
    endcase
    row.typed = 1'b0;
    row.st = '0; row.conn = 1'b0; row.start = 1'b0; row.drop = 1'b0; row.acc = 1'b0;
    send_event(row);
  endtask

  task automatic run_phase(logic [31:0] tmo, logic [30:0] bmin, logic [30:0] bmax,
                           logic cred, int n, bit pace, bit hold, bit pause);
    drain();
    write_reg(REG_CONNECT_TIMEOUT, tmo);
    write_reg(REG_BACKOFF_MIN, {1'b0, bmin});
    write_reg(REG_BACKOFF_MAX, {1'b0, bmax});
    write_reg(REG_HAS_CRED, {31'b0, cred});
    src_pace  = pace;
    sink_pace = pace;
    now_cur   = $urandom();
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && hold) hold_req = 1'b1;
      if (i == n / 2 && pause) drain();
      send_random();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : res_chk
    lrb_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[133:0];
      if (link_report_q.size() == 0) begin
        report_err("result item with nothing pending");
      end else begin
        want = link_report_q.pop_front();
        check_fld("link_state", 32'(got.link_state), 32'(want.link_state));
        check_fld("connected", 32'(got.connected), 32'(want.connected));
        check_fld("start_attempt", 32'(got.start_attempt), 32'(want.start_attempt));
        check_fld("drop_link", 32'(got.drop_link), 32'(want.drop_link));
        check_fld("accepted", 32'(got.accepted), 32'(want.accepted));
        check_fld("attempt_count", got.attempt_count, want.attempt_count);
        check_fld("disconnect_total", got.disconnect_total, want.disconnect_total);
        check_fld("failure_run", got.failure_run, want.failure_run);
        check_fld("backoff_now_ms", 32'(got.backoff_now_ms), 32'(want.backoff_now_ms));
      end
      result_idx++;
    end
  end

  // watchdog: end the run when no channel moves an item for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result receiver
  initial begin : sink
    int unsigned stall;
    m_axis_tready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (sink_pace && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : main
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_CONNECT_TIMEOUT;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_TICK;

    lnk_state = LS_IDLE; att_start = '0; backoff = '0; deadline = '0;
    n_attempts = '0; n_drops = '0; n_fails = '0;
    cfg_timeout = TIMEOUT_RST; cfg_bmin = BACKOFF_MIN_RST; cfg_bmax = BACKOFF_MAX_RST;
    cfg_cred = 1'b0;

    // register values after reset: 15000 ms timeout, 1000..60000 backoff, no credentials
    event_table.push_back(mk_row(MODE_TICK, 32'd0, 0, 0, 1, LS_IDLE, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_RSVD6, 32'd123, 1, 1, 1, LS_IDLE, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_RSVD7, 32'hFFFF_FFFF, 1, 1, 1, LS_IDLE, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_INIT, 32'd100, 0, 0, 1, LS_NOCRED, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_TICK, 32'hFFFF_FFFF, 1, 1, 1, LS_NOCRED, 0, 0, 0, 0));
    // request without a network name is refused
    event_table.push_back(mk_row(MODE_CONNECT, 32'd200, 0, 0, 1, LS_NOCRED, 0, 0, 0, 0));
    // attempt started just before the time wraps; timeout lands after the wrap
    event_table.push_back(mk_row(MODE_CONNECT, 32'hFFFF_FF00, 0, 1, 1, LS_CONNECTING, 0, 1, 0, 1));
    event_table.push_back(mk_row(MODE_TICK, 32'd14743, 0, 0, 1, LS_CONNECTING, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_TICK, 32'd14744, 0, 0, 1, LS_WAIT, 0, 0, 1, 0));
    event_table.push_back(mk_row(MODE_TICK, 32'd16743, 0, 0, 1, LS_WAIT, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_TICK, 32'd16744, 0, 0, 1, LS_NOCRED, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_CONNECT, 32'd20000, 1, 1, 1, LS_CONNECTING, 0, 1, 0, 1));
    event_table.push_back(mk_row(MODE_TICK, 32'd20001, 1, 0, 1, LS_CONNECTED, 1, 0, 0, 0));
    // link loss: reconnect wait without a drop command
    event_table.push_back(mk_row(MODE_TICK, 32'd20002, 0, 0, 1, LS_WAIT, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_PROV_START, 32'd20003, 0, 0, 1, LS_PROV, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_PROV_START, 32'd20004, 0, 0, 1, LS_PROV, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_TICK, 32'd20005, 1, 0, 1, LS_PROV, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_PROV_STOP, 32'd20006, 0, 0, 1, LS_IDLE, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_PROV_STOP, 32'd20007, 0, 0, 1, LS_IDLE, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_PROV_START, 32'd20008, 0, 0, 1, LS_PROV, 0, 0, 0, 0));
    // a named request ends provisioning
    event_table.push_back(mk_row(MODE_CONNECT, 32'd20009, 0, 1, 1, LS_CONNECTING, 0, 1, 0, 1));
    event_table.push_back(mk_row(MODE_SHUTDOWN, 32'd20010, 1, 0, 1, LS_IDLE, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_CONNECT, 32'd0, 0, 1, 0, '0, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_TICK, 32'd15000, 0, 0, 0, '0, 0, 0, 0, 0));
    // deadline at 17000: half the range later still counts as not yet passed
    event_table.push_back(mk_row(MODE_TICK, 32'h8000_4268, 0, 0, 1, LS_WAIT, 0, 0, 0, 0));
    event_table.push_back(mk_row(MODE_TICK, 32'h8000_4267, 0, 0, 1, LS_NOCRED, 0, 0, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_pace  = 1'b1;
    sink_pace = 1'b1;
    foreach (event_table[i]) send_event(event_table[i]);

    run_phase(32'd15000, 31'd1000, 31'd60000, 1'b1, 250, 1'b1, 1'b1, 1'b0);
    run_phase(32'd1, 31'd1, 31'h7FFF_FFFF, 1'b1, 200, 1'b1, 1'b0, 1'b1);
    run_phase(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 150, 1'b1, 1'b0, 1'b0);
    // minimum above maximum
    run_phase(32'd5000, 31'h7FFF_FFFF, 31'd1, 1'b0, 150, 1'b1, 1'b0, 1'b0);
    run_phase($urandom_range(1, 40000), 31'($urandom_range(1, 5000)),
              31'($urandom_range(1, 200000)), 1'b1, 250, 1'b0, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* link_reconnect_backoff_fsm_unit.f */
rtl/lrb_pkg.sv
rtl/lrb_step.sv
rtl/link_reconnect_backoff_fsm_unit.sv
tb/sv/link_reconnect_backoff_fsm_unit_tb.sv
